// ===== rtl/cbc_pkg.sv =====
// Shared types and constants for the cartridge bank controller.
package cbc_pkg;

  localparam int unsigned MAX_RAM_BANKS_DEF = 16;
  localparam int unsigned MAX_ROM_BANKS     = 512;
  localparam int unsigned RAM_BANK_BYTES    = 8192;

  localparam logic [8:0] ROM_LIMIT_MASK = 9'(MAX_ROM_BANKS - 1);

  localparam logic [2:0] SCHEME_NONE = 3'd0;
  localparam logic [2:0] SCHEME_MBC1 = 3'd1;
  localparam logic [2:0] SCHEME_MBC2 = 3'd2;
  localparam logic [2:0] SCHEME_MBC3 = 3'd3;
  localparam logic [2:0] SCHEME_MBC5 = 3'd4;

  localparam logic [1:0] CFG_BANK_SCHEME   = 2'd0;
  localparam logic [1:0] CFG_ROM_COUNT     = 2'd1;
  localparam logic [1:0] CFG_RAM_COUNT     = 2'd2;
  localparam logic [1:0] CFG_BOOT_PRESENT  = 2'd3;

  localparam logic [1:0] TGT_VALUE = 2'd0;
  localparam logic [1:0] TGT_ROM   = 2'd1;
  localparam logic [1:0] TGT_BOOT  = 2'd2;
  localparam logic [1:0] TGT_RAM   = 2'd3;

  localparam logic       FUNC_WRITE = 1'b1;

  localparam logic [15:0] ADDR_BOOT_OFF = 16'hFF50;
  localparam logic [15:0] ADDR_BOOT_END = 16'h00FF;
  localparam logic [15:0] ADDR_ROM0_END = 16'h3FFF;
  localparam logic [15:0] ADDR_ROM_END  = 16'h7FFF;
  localparam logic [15:0] ADDR_RAMEN_END = 16'h1FFF;
  localparam logic [15:0] ADDR_ROMLO_END = 16'h2FFF;
  localparam logic [15:0] ADDR_BANK2_END = 16'h5FFF;
  localparam logic [15:0] ADDR_RAM_BASE = 16'hA000;
  localparam logic [15:0] ADDR_RAM_END  = 16'hBFFF;

  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
  localparam logic [7:0] STATUS_BASE    = 8'hFE;
  localparam logic [7:0] OPEN_BUS       = 8'hFF;
  localparam logic [3:0] NIBBLE_FILL    = 4'hF;

  typedef struct packed {
    logic        func;
    logic [15:0] address;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [22:0] rom_address;
    logic [7:0]  boot_address;
    logic [7:0]  read_data;
  } out_item_t;

endpackage

// ===== rtl/cartridge_bank_controller_top.sv =====
// Cartridge bank controller: bank registers, boot ROM mapping and cartridge RAM store.
// A beat's result and RAM store read are registered in the pending stage, then output.
// Throughput: one beat per cycle, except while clearing or while out_stall holds a beat.
// Reset: bank registers and config return to defaults at once; then a clearing pass zeroes
// the RAM store, MAX_RAM_BANKS * 8192 bytes (131072 by default), with input stalled.
// Config writes are taken during the clearing pass.
module cartridge_bank_controller_top
  import cbc_pkg::*;
#(
  parameter int unsigned MAX_RAM_BANKS = MAX_RAM_BANKS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_wdata,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_payload,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_payload
);

  localparam int unsigned DEPTH  = MAX_RAM_BANKS * RAM_BANK_BYTES;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam logic [3:0]  RAM_LIMIT_MASK = 4'(MAX_RAM_BANKS - 1);
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);

  logic [2:0] scheme_r;
  logic [9:0] rom_cnt_r;
  logic [4:0] ram_cnt_r;
  logic       boot_present_r;

  logic [8:0] rom_bank_r, rom_bank_nxt;
  logic [1:0] upper_r, upper_nxt;
  logic [3:0] ram_bank_r, ram_bank_nxt;
  logic       ram_en_r, ram_en_nxt;
  logic       adv_r, adv_nxt;
  logic       boot_dis_r, boot_dis_nxt;

  logic              clearing_r;
  logic [ADDR_W-1:0] clr_idx_r;

  logic [7:0] mem [0:DEPTH-1];
  logic [7:0] ram_rdata_r;

  logic      pend_r;
  out_item_t pend_item_r;
  logic      ram_src_r, nib_r;
  logic      out_valid_r;
  out_item_t out_r, out_nxt;

  logic        accept, advance;
  logic [15:0] addr;
  logic [7:0]  din;
  logic [8:0]  rom_mask, rom_bank_rd;
  logic [8:0]  rom_sum;
  logic [3:0]  ram_mask, ram_bank_eff;
  logic        boot_mapped, is_ram, is_mbc;
  logic        ram_reach;
  logic [ADDR_W-1:0] ram_idx;
  logic        mem_re, mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]  mem_wdata;
  out_item_t   res;
  logic        res_ram, res_nib;

  assign addr    = in_payload.address;
  assign din     = in_payload.data;
  assign in_stall = clearing_r || (pend_r && out_valid_r && out_stall);
  assign accept  = in_valid && !in_stall;
  assign advance = pend_r && (!out_valid_r || !out_stall);

  assign rom_mask = (rom_cnt_r == 10'd0) ? 9'd0 : (rom_cnt_r[8:0] - 9'd1) & ROM_LIMIT_MASK;
  assign ram_mask = (ram_cnt_r == 5'd0) ? 4'd0 : (ram_cnt_r[3:0] - 4'd1) & RAM_LIMIT_MASK;
  assign boot_mapped = boot_present_r && !boot_dis_r;
  assign is_ram = (addr >= ADDR_RAM_BASE) && (addr <= ADDR_RAM_END);
  assign is_mbc = (scheme_r >= SCHEME_MBC1) && (scheme_r <= SCHEME_MBC5);
  assign ram_reach = ram_en_r && (ram_cnt_r != 5'd0);
  assign rom_sum = {2'b00, upper_r, 5'd0} + rom_bank_r;

  always_comb begin
    if (scheme_r == SCHEME_MBC1) begin
      ram_bank_eff = (adv_r ? {2'b00, upper_r} : 4'd0) & ram_mask;
    end else begin
      ram_bank_eff = ram_bank_r;
    end
    if (scheme_r == SCHEME_MBC2) begin
      ram_idx = ADDR_W'(addr[8:0]);
    end else begin
      ram_idx = ADDR_W'({ram_bank_eff & RAM_LIMIT_MASK, addr[12:0]});
    end
  end

  always_comb begin
    if (addr <= ADDR_ROM0_END) begin
      rom_bank_rd = (scheme_r == SCHEME_MBC1 && adv_r) ? ({2'b00, upper_r, 5'd0} & rom_mask)
                                                       : 9'd0;
    end else begin
      case (scheme_r)
        SCHEME_MBC1: rom_bank_rd = rom_sum & rom_mask;
        SCHEME_MBC3: rom_bank_rd = rom_bank_r & rom_mask;
        SCHEME_MBC2, SCHEME_MBC5: rom_bank_rd = rom_bank_r;
        default: rom_bank_rd = 9'd1;
      endcase
    end
  end

  always_comb begin
    res       = '0;
    res_ram   = 1'b0;
    res_nib   = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = ram_idx;
    mem_wdata = din;
    rom_bank_nxt = rom_bank_r;
    upper_nxt    = upper_r;
    ram_bank_nxt = ram_bank_r;
    ram_en_nxt   = ram_en_r;
    adv_nxt      = adv_r;
    boot_dis_nxt = boot_dis_r;
    if (in_payload.func == FUNC_WRITE) begin
      if (addr == ADDR_BOOT_OFF && boot_mapped) begin
        boot_dis_nxt = 1'b1;
      end else if (is_ram) begin
        if (scheme_r == SCHEME_MBC2) begin
          mem_we    = ram_en_r;
          mem_wdata = {4'd0, din[3:0]};
        end else if (is_mbc) begin
          mem_we = ram_reach;
        end
      end else if (addr <= ADDR_ROM_END) begin
        case (scheme_r)
          SCHEME_MBC1: begin
            if (addr <= ADDR_RAMEN_END) begin
              ram_en_nxt = din[3:0] == RAM_ENABLE_KEY;
            end else if (addr <= ADDR_ROM0_END) begin
              rom_bank_nxt = (din[4:0] != 5'd0) ? {4'd0, din[4:0]} : 9'd1;
            end else if (addr <= ADDR_BANK2_END) begin
              upper_nxt = din[1:0];
            end else begin
              adv_nxt = din[0];
            end
          end
          SCHEME_MBC2: begin
            if (addr <= ADDR_ROM0_END) begin
              if (addr[8]) begin
                rom_bank_nxt = (din[3:0] != 4'd0) ? ({5'd0, din[3:0]} & rom_mask) : 9'd1;
              end else begin
                ram_en_nxt = din[3:0] == RAM_ENABLE_KEY;
              end
            end
          end
          SCHEME_MBC3: begin
            if (addr <= ADDR_RAMEN_END) begin
              ram_en_nxt = din[3:0] == RAM_ENABLE_KEY;
            end else if (addr <= ADDR_ROM0_END) begin
              rom_bank_nxt = (din[6:0] != 7'd0) ? {2'd0, din[6:0]} : 9'd1;
            end else if (addr <= ADDR_BANK2_END) begin
              ram_bank_nxt = {2'd0, din[1:0]} & ram_mask;
            end
          end
          SCHEME_MBC5: begin
            if (addr <= ADDR_RAMEN_END) begin
              ram_en_nxt = din[3:0] == RAM_ENABLE_KEY;
            end else if (addr <= ADDR_ROMLO_END) begin
              rom_bank_nxt = {rom_bank_r[8], din} & rom_mask;
            end else if (addr <= ADDR_ROM0_END) begin
              rom_bank_nxt = {din[0], rom_bank_r[7:0]} & rom_mask;
            end else if (addr <= ADDR_BANK2_END) begin
              ram_bank_nxt = din[3:0] & ram_mask;
            end
          end
          default: begin
          end
        endcase
      end
    end else if (addr == ADDR_BOOT_OFF) begin
      res.read_data = STATUS_BASE | {7'd0, boot_mapped};
    end else if (boot_mapped && addr <= ADDR_BOOT_END) begin
      res.target       = TGT_BOOT;
      res.boot_address = addr[7:0];
    end else if (addr <= ADDR_ROM_END) begin
      res.target      = TGT_ROM;
      res.rom_address = {rom_bank_rd, addr[13:0]};
    end else if (is_ram) begin
      res.target    = TGT_RAM;
      res.read_data = OPEN_BUS;
      if (scheme_r == SCHEME_MBC2) begin
        res_ram = ram_en_r;
        res_nib = 1'b1;
      end else if (is_mbc) begin
        res_ram = ram_reach;
      end
      mem_re = res_ram;
    end else begin
      res.read_data = OPEN_BUS;
    end
    if (clearing_r) begin
      mem_we    = 1'b1;
      mem_addr  = clr_idx_r;
      mem_wdata = 8'd0;
    end else if (!accept) begin
      mem_we = 1'b0;
      mem_re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      ram_rdata_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scheme_r       <= SCHEME_NONE;
      rom_cnt_r      <= 10'd2;
      ram_cnt_r      <= 5'd0;
      boot_present_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BANK_SCHEME:  scheme_r       <= cfg_wdata[2:0];
        CFG_ROM_COUNT:    rom_cnt_r      <= cfg_wdata;
        CFG_RAM_COUNT:    ram_cnt_r      <= cfg_wdata[4:0];
        CFG_BOOT_PRESENT: boot_present_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_r <= 9'd1;
      upper_r    <= 2'd0;
      ram_bank_r <= 4'd0;
      ram_en_r   <= 1'b0;
      adv_r      <= 1'b0;
      boot_dis_r <= 1'b0;
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      if (clearing_r) begin
        clr_idx_r <= clr_idx_r + ADDR_W'(1);
        if (clr_idx_r == LAST_IDX) begin
          clearing_r <= 1'b0;
        end
      end
      if (accept) begin
        rom_bank_r <= rom_bank_nxt;
        upper_r    <= upper_nxt;
        ram_bank_r <= ram_bank_nxt;
        ram_en_r   <= ram_en_nxt;
        adv_r      <= adv_nxt;
        boot_dis_r <= boot_dis_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        pend_r <= 1'b1;
      end else if (advance) begin
        pend_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    out_nxt = pend_item_r;
    if (ram_src_r) begin
      out_nxt.read_data = nib_r ? {NIBBLE_FILL, ram_rdata_r[3:0]} : ram_rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_item_r <= res;
      ram_src_r   <= res_ram;
      nib_r       <= res_nib;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

  a_rise_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pend_r))
    else $error("result shown without a pending beat");

  a_hold_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && out_valid_r && out_stall) |=> (pend_r && $stable(ram_rdata_r)))
    else $error("pending beat lost while output blocked");

  a_boot_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    boot_dis_r |=> boot_dis_r)
    else $error("boot ROM disable cleared without reset");

  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clearing_r) |-> ($past(clr_idx_r) == LAST_IDX))
    else $error("clearing pass ended early");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |=> !pend_r)
    else $error("beat taken during clearing pass");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the cartridge bank controller: bus accesses against a bank model.
`timescale 1ns / 100ps

module testbench;
  import cbc_pkg::*;

  localparam logic FUNC_READ    = ~FUNC_WRITE;
  localparam int   CYCLE_LIMIT  = 1_000_000;
  localparam int   HOLD_CYCLES  = 300;
  localparam int   DRAIN_CYCLES = 4;
  localparam int   PRINT_CAP    = 40;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [9:0] cfg_wdata = '0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_payload = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_payload;

  bit in_gaps_on  = 1'b1;
  bit out_gaps_on = 1'b1;
  bit hold_req    = 1'b0;
  int fail_count  = 0;
  int cycle_count = 0;

  out_item_t pending_results[$];

  logic [2:0] setup_scheme    = SCHEME_NONE;
  logic [9:0] setup_rom_count = 10'd2;
  logic [4:0] setup_ram_count = 5'd0;
  logic       setup_boot      = 1'b0;

  logic [8:0] cart_rom_bank = 9'd1;
  logic [1:0] cart_upper    = 2'd0;
  logic [3:0] cart_ram_bank = 4'd0;
  logic       cart_ram_en   = 1'b0;
  logic       cart_adv      = 1'b0;
  logic       cart_boot_off = 1'b0;
  bit   [7:0] ram_mem [0:131071];

  cartridge_bank_controller_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [8:0] rom_mask_now();
    return (setup_rom_count == 10'd0) ? 9'd0 : 9'(setup_rom_count - 10'd1);
  endfunction

  function automatic logic [3:0] ram_mask_now();
    return (setup_ram_count == 5'd0) ? 4'd0 : 4'(setup_ram_count - 5'd1);
  endfunction

  function automatic logic boot_live();
    return setup_boot && !cart_boot_off;
  endfunction

  // bit 4 flags a reachable RAM bank
  function automatic logic [4:0] ram_bank_live();
    if (!cart_ram_en || setup_ram_count == 5'd0) return 5'd0;
    if (setup_scheme == SCHEME_MBC1)
      return {1'b1, (cart_adv ? {2'b00, cart_upper} : 4'd0) & ram_mask_now()};
    return {1'b1, cart_ram_bank};
  endfunction

  function automatic logic banked_ram();
    return setup_scheme == SCHEME_MBC1 || setup_scheme == SCHEME_MBC3 ||
           setup_scheme == SCHEME_MBC5;
  endfunction

  function automatic void apply_write(input logic [15:0] addr, input logic [7:0] val);
    logic [4:0] live;
    live = ram_bank_live();
    if (addr >= ADDR_RAM_BASE && addr <= ADDR_RAM_END) begin
      if (setup_scheme == SCHEME_MBC2) begin
        if (cart_ram_en) ram_mem[addr[8:0]] = {4'h0, val[3:0]};
      end else if (banked_ram() && live[4]) begin
        ram_mem[{live[3:0], addr[12:0]}] = val;
      end
      return;
    end
    if (addr > ADDR_ROM_END) return;
    case (setup_scheme)
      SCHEME_MBC1: begin
        if (addr <= ADDR_RAMEN_END) cart_ram_en = (val[3:0] == RAM_ENABLE_KEY);
        else if (addr <= ADDR_ROM0_END)
          cart_rom_bank = (val[4:0] == 5'd0) ? 9'd1 : {4'd0, val[4:0]};
        else if (addr <= ADDR_BANK2_END) cart_upper = val[1:0];
        else cart_adv = val[0];
      end
      SCHEME_MBC2: begin
        if (addr <= ADDR_ROM0_END) begin
          if (addr[8])
            cart_rom_bank = (val[3:0] == 4'd0) ? 9'd1 : ({5'd0, val[3:0]} & rom_mask_now());
          else
            cart_ram_en = (val[3:0] == RAM_ENABLE_KEY);
        end
      end
      SCHEME_MBC3: begin
        if (addr <= ADDR_RAMEN_END) cart_ram_en = (val[3:0] == RAM_ENABLE_KEY);
        else if (addr <= ADDR_ROM0_END)
          cart_rom_bank = (val[6:0] == 7'd0) ? 9'd1 : {2'd0, val[6:0]};
        else if (addr <= ADDR_BANK2_END) cart_ram_bank = {2'b00, val[1:0]} & ram_mask_now();
      end
      SCHEME_MBC5: begin
        if (addr <= ADDR_RAMEN_END) cart_ram_en = (val[3:0] == RAM_ENABLE_KEY);
        else if (addr <= ADDR_ROMLO_END)
          cart_rom_bank = {cart_rom_bank[8], val} & rom_mask_now();
        else if (addr <= ADDR_ROM0_END)
          cart_rom_bank = {val[0], cart_rom_bank[7:0]} & rom_mask_now();
        else if (addr <= ADDR_BANK2_END) cart_ram_bank = val[3:0] & ram_mask_now();
      end
      default: ;
    endcase
  endfunction

  function automatic out_item_t predict_access(input in_item_t acc);
    out_item_t  res;
    logic [8:0] bank;
    logic [4:0] live;
    res = '0;
    live = ram_bank_live();
    if (acc.func == FUNC_WRITE) begin
      if (acc.address == ADDR_BOOT_OFF && boot_live()) cart_boot_off = 1'b1;
      else apply_write(acc.address, acc.data);
    end else if (acc.address == ADDR_BOOT_OFF) begin
      res.target    = TGT_VALUE;
      res.read_data = STATUS_BASE | {7'd0, boot_live()};
    end else if (boot_live() && acc.address <= ADDR_BOOT_END) begin
      res.target       = TGT_BOOT;
      res.boot_address = acc.address[7:0];
    end else if (acc.address <= ADDR_ROM_END) begin
      res.target = TGT_ROM;
      if (acc.address <= ADDR_ROM0_END) begin
        bank = (setup_scheme == SCHEME_MBC1 && cart_adv) ?
               ({2'b00, cart_upper, 5'd0} & rom_mask_now()) : 9'd0;
      end else begin
        case (setup_scheme)
          SCHEME_MBC1: bank = ({2'b00, cart_upper, 5'd0} + cart_rom_bank) & rom_mask_now();
          SCHEME_MBC3: bank = cart_rom_bank & rom_mask_now();
          SCHEME_MBC2, SCHEME_MBC5: bank = cart_rom_bank;
          default: bank = 9'd1;
        endcase
      end
      res.rom_address = {bank, acc.address[13:0]};
    end else if (acc.address >= ADDR_RAM_BASE && acc.address <= ADDR_RAM_END) begin
      res.target    = TGT_RAM;
      res.read_data = OPEN_BUS;
      if (setup_scheme == SCHEME_MBC2) begin
        if (cart_ram_en) res.read_data = {NIBBLE_FILL, ram_mem[acc.address[8:0]][3:0]};
      end else if (banked_ram() && live[4]) begin
        res.read_data = ram_mem[{live[3:0], acc.address[12:0]}];
      end
    end else begin
      res.target    = TGT_VALUE;
      res.read_data = OPEN_BUS;
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    fail_count++;
    if (fail_count <= PRINT_CAP)
      $display("mismatch on %s: got %0h, want %0h (cycle %0d)", what, got, want, cycle_count);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing pending", 32'(out_payload), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_payload.target !== want.target)
          flag_mismatch("target", 32'(out_payload.target), 32'(want.target));
        if (out_payload.rom_address !== want.rom_address)
          flag_mismatch("rom_address", 32'(out_payload.rom_address), 32'(want.rom_address));
        if (out_payload.boot_address !== want.boot_address)
          flag_mismatch("boot_address", 32'(out_payload.boot_address),
                        32'(want.boot_address));
        if (out_payload.read_data !== want.read_data)
          flag_mismatch("read_data", 32'(out_payload.read_data), 32'(want.read_data));
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (out_gaps_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_item_t make_access(input logic f, input logic [15:0] a,
                                           input logic [7:0] d);
    in_item_t acc;
    acc.func    = f;
    acc.address = a;
    acc.data    = d;
    return acc;
  endfunction

  function automatic in_item_t random_access();
    in_item_t    acc;
    int unsigned pick;
    acc.func    = 1'($urandom_range(0, 1));
    acc.address = 16'($urandom_range(0, 16'hFFFF));
    acc.data    = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      acc.func    = FUNC_WRITE;
      acc.address = 16'($urandom_range(0, ADDR_RAMEN_END));
      if (pick < 8) acc.data[3:0] = RAM_ENABLE_KEY;
    end else if (pick < 26) begin
      acc.func    = FUNC_WRITE;
      acc.address = 16'($urandom_range(ADDR_RAMEN_END + 16'd1, ADDR_ROM_END));
    end else if (pick < 58) begin
      acc.address[15:13] = ADDR_RAM_BASE[15:13];
      if (pick < 42) acc.address[12:0] = 13'($urandom_range(0, 31));
    end else if (pick < 82) begin
      acc.func        = FUNC_READ;
      acc.address[15] = 1'b0;
    end else if (pick < 84) begin
      acc.address = ADDR_BOOT_OFF;
    end
    return acc;
  endfunction

  task automatic send_access(input in_item_t acc);
    if (in_gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_payload <= acc;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_results.push_back(predict_access(acc));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_beat(input logic [1:0] idx, input logic [9:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_setup(input logic [2:0] scheme, input logic [9:0] rom_cnt,
                            input logic [4:0] ram_cnt, input logic boot);
    cfg_beat(CFG_BANK_SCHEME, 10'(scheme));
    cfg_beat(CFG_ROM_COUNT, rom_cnt);
    cfg_beat(CFG_RAM_COUNT, 10'(ram_cnt));
    cfg_beat(CFG_BOOT_PRESENT, 10'(boot));
    cfg_we <= 1'b0;
    setup_scheme    = scheme;
    setup_rom_count = rom_cnt;
    setup_ram_count = ram_cnt;
    setup_boot      = boot;
  endtask

  task automatic run_mix(input logic [2:0] scheme, input logic [9:0] rom_cnt,
                         input logic [4:0] ram_cnt, input logic boot, input int count);
    load_setup(scheme, rom_cnt, ram_cnt, boot);
    repeat (count) send_access(random_access());
    settle();
  endtask

  task automatic test_boot_rom();
    load_setup(SCHEME_NONE, 10'd2, 5'd0, 1'b1);
    send_access(make_access(FUNC_READ, 16'h0000, 8'h00));
    send_access(make_access(FUNC_READ, ADDR_BOOT_END, 8'hFF));
    send_access(make_access(FUNC_READ, 16'h0100, 8'h00));
    send_access(make_access(FUNC_READ, ADDR_BOOT_OFF, 8'h00));
    send_access(make_access(FUNC_WRITE, 16'h2000, 8'h05));
    send_access(make_access(FUNC_READ, 16'h4000, 8'h00));
    repeat (20)
      send_access(make_access(FUNC_READ, 16'($urandom_range(0, 16'h01FF)),
                              8'($urandom_range(0, 255))));
    send_access(make_access(FUNC_WRITE, ADDR_BOOT_OFF, 8'h01));
    send_access(make_access(FUNC_READ, ADDR_BOOT_OFF, 8'h00));
    send_access(make_access(FUNC_READ, 16'h0000, 8'h00));
    send_access(make_access(FUNC_WRITE, ADDR_BOOT_OFF, 8'h00));
    send_access(make_access(FUNC_READ, ADDR_ROM_END, 8'h00));
    send_access(make_access(FUNC_READ, 16'h8000, 8'h00));
    send_access(make_access(FUNC_READ, ADDR_RAM_BASE, 8'h00));
    send_access(make_access(FUNC_WRITE, ADDR_RAM_BASE, 8'hAA));
    send_access(make_access(FUNC_READ, 16'hFFFF, 8'h00));
    send_access(make_access(FUNC_WRITE, 16'hFFFF, 8'hFF));
    settle();
  endtask

  task automatic test_bank_select();
    load_setup(SCHEME_MBC1, 10'd512, 5'd16, 1'b0);
    send_access(make_access(FUNC_WRITE, 16'h2000, 8'h00));
    send_access(make_access(FUNC_READ, 16'h4000, 8'h00));
    send_access(make_access(FUNC_WRITE, ADDR_ROM0_END, 8'hFF));
    send_access(make_access(FUNC_READ, ADDR_ROM_END, 8'h00));
    send_access(make_access(FUNC_READ, ADDR_RAM_END, 8'h00));
    send_access(make_access(FUNC_WRITE, 16'h0000, 8'h0A));
    send_access(make_access(FUNC_WRITE, ADDR_RAM_END, 8'hFF));
    send_access(make_access(FUNC_READ, ADDR_RAM_END, 8'h00));
    send_access(make_access(FUNC_WRITE, 16'h4000, 8'h03));
    send_access(make_access(FUNC_WRITE, 16'h6000, 8'h01));
    send_access(make_access(FUNC_READ, 16'h0000, 8'h00));
    send_access(make_access(FUNC_READ, 16'h4000, 8'h00));
    send_access(make_access(FUNC_WRITE, ADDR_RAM_BASE, 8'h5A));
    send_access(make_access(FUNC_READ, ADDR_RAM_BASE, 8'h00));
    settle();
  endtask

  task automatic test_mbc1();
    run_mix(SCHEME_MBC1, 10'd512, 5'd16, 1'b0, 90);
    run_mix(SCHEME_MBC1, 10'd2, 5'd0, 1'b1, 90);
    run_mix(SCHEME_MBC1, 10'd64, 5'd4, 1'b0, 90);
  endtask

  task automatic test_mbc2();
    run_mix(SCHEME_MBC2, 10'd16, 5'd0, 1'b0, 80);
    run_mix(SCHEME_MBC2, 10'd512, 5'd16, 1'b1, 80);
  endtask

  task automatic test_mbc3();
    run_mix(SCHEME_MBC3, 10'd128, 5'd4, 1'b0, 80);
    run_mix(SCHEME_MBC3, 10'd2, 5'd1, 1'b0, 80);
  endtask

  task automatic test_unbanked();
    run_mix(SCHEME_NONE, 10'd32, 5'd4, 1'b1, 60);
  endtask

  task automatic test_mbc5();
    run_mix(SCHEME_MBC5, 10'd512, 5'd16, 1'b0, 90);
    run_mix(SCHEME_MBC5, 10'd8, 5'd8, 1'b0, 90);
  endtask

  task automatic test_backpressure();
    load_setup(SCHEME_MBC3, 10'd256, 5'd8, 1'b0);
    hold_req = 1'b1;
    repeat (60) send_access(random_access());
    settle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_boot_rom();
    test_bank_select();
    test_mbc1();
    test_mbc2();
    test_mbc3();
    test_unbanked();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    test_mbc5();
    test_backpressure();
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
